/* hdl/sgrf_pkg.sv */
// Shared types, constants and the frame byte table for the SNMP GetRequest framer.
package sgrf_pkg;

  // Longest encoded OID accepted by a start item.
  localparam logic [5:0] MAX_OID_BYTES = 6'd32;

  // Longest message that still fits a short-form BER length.
  localparam logic [7:0] MAX_SHORT_LEN = 8'd127;

  // Fixed part of the message length beyond the community and the OID.
  localparam logic [7:0] MSG_OVERHEAD = 8'd27;

  // Size of the command queue between the front end and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_COMM  = 2'd1,
    KIND_OID   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  // Position of the front end inside a frame.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_COMM = 2'd1,
    PH_OID  = 2'd2
  } phase_t;

  // Burst types handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_HEAD = 2'd0,
    OP_PASS = 2'd1,
    OP_ERR  = 2'd2
  } op_t;

  // One queued burst command.
  typedef struct packed {
    op_t        op;
    logic       do_pdu;
    logic       do_close;
    logic [7:0] data;
    logic [5:0] len;
    logic [7:0] req_id;
    logic       next_req;
  } cmd_t;

  // Steps of the output script.
  typedef logic [4:0] step_t;

  localparam step_t STEP_HEAD     = 5'd0;
  localparam step_t STEP_HEAD_END = 5'd6;
  localparam step_t STEP_PASS     = 5'd7;
  localparam step_t STEP_ERR      = 5'd8;
  localparam step_t STEP_PDU      = 5'd9;
  localparam step_t STEP_PDU_END  = 5'd28;
  localparam step_t STEP_NULL     = 5'd29;
  localparam step_t STEP_END      = 5'd30;

  // BER tags and fixed bytes.
  localparam logic [7:0] TAG_SEQ     = 8'h30;
  localparam logic [7:0] TAG_GET     = 8'hA0;
  localparam logic [7:0] TAG_GETNEXT = 8'hA1;
  localparam logic [7:0] TAG_INT     = 8'h02;
  localparam logic [7:0] TAG_OCTETS  = 8'h04;
  localparam logic [7:0] TAG_OID     = 8'h06;
  localparam logic [7:0] TAG_NULL    = 8'h05;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_FOUR   = 8'h04;

  // Byte emitted at a given step of the output script.
  function automatic logic [7:0] frame_byte(
    input step_t      step,
    input logic [6:0] comm_size,
    input logic [5:0] oid_len,
    input logic [7:0] req_id,
    input logic       next_req,
    input logic [7:0] data
  );
    logic [7:0] len8;
    logic [7:0] res;
    len8 = {2'b00, oid_len};
    case (step)
      5'd0:    res = TAG_SEQ;
      5'd1:    res = {1'b0, comm_size} + len8 + MSG_OVERHEAD;
      5'd2:    res = TAG_INT;
      5'd3:    res = BYTE_ONE;
      5'd4:    res = BYTE_ONE;
      5'd5:    res = TAG_OCTETS;
      5'd6:    res = {1'b0, comm_size};
      5'd7:    res = data;
      5'd8:    res = BYTE_ZERO;
      5'd9:    res = next_req ? TAG_GETNEXT : TAG_GET;
      5'd10:   res = len8 + 8'd20;
      5'd11:   res = TAG_INT;
      5'd12:   res = BYTE_FOUR;
      5'd13:   res = BYTE_ZERO;
      5'd14:   res = BYTE_ZERO;
      5'd15:   res = BYTE_ZERO;
      5'd16:   res = req_id;
      5'd17:   res = TAG_INT;
      5'd18:   res = BYTE_ONE;
      5'd19:   res = BYTE_ZERO;
      5'd20:   res = TAG_INT;
      5'd21:   res = BYTE_ONE;
      5'd22:   res = BYTE_ZERO;
      5'd23:   res = TAG_SEQ;
      5'd24:   res = len8 + 8'd6;
      5'd25:   res = TAG_SEQ;
      5'd26:   res = len8 + 8'd4;
      5'd27:   res = TAG_OID;
      5'd28:   res = len8;
      5'd29:   res = TAG_NULL;
      5'd30:   res = BYTE_ZERO;
      default: res = BYTE_ZERO;
    endcase
    return res;
  endfunction

endpackage

/* hdl/sgrf_if.sv */
// Valid/ready channel interfaces for the framer's input and output items.
interface sgrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [6:0] community_length;
  logic [5:0] oid_length;
  logic [7:0] req_number;
  logic       next_request;

  modport source (
    output valid, kind, data_byte, community_length, oid_length, req_number, next_request,
    input  ready
  );
  modport sink (
    input  valid, kind, data_byte, community_length, oid_length, req_number, next_request,
    output ready
  );
endinterface

interface sgrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (
    output valid, out_byte, last, error,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last, error,
    output ready
  );
endinterface

/* hdl/sgrf_front.sv */
// Front end: accepts input items, tracks the frame phase and queues burst commands.
module sgrf_front import sgrf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sgrf_in_if.sink      in_chan,
  output logic         push_valid,
  input  logic         push_ready,
  output cmd_t         push_cmd
);

  phase_t     phase_r, phase_nxt;
  logic [6:0] comm_left_r, comm_left_nxt;
  logic [5:0] oid_left_r, oid_left_nxt;
  logic [5:0] saved_len_r, saved_len_nxt;

  logic       accept;
  kind_t      kind;
  logic [7:0] total;
  logic       start_ok;
  logic       comm_ok;
  logic       oid_ok;
  logic [6:0] comm_dec;
  logic [5:0] oid_dec;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && push_ready;
  assign push_valid    = accept;
  assign kind          = kind_t'(in_chan.kind);

  // Classification of the current item against the frame state.
  assign total    = {1'b0, in_chan.community_length} + {2'b00, in_chan.oid_length}
                    + MSG_OVERHEAD;
  assign start_ok = (phase_r == PH_IDLE) && (in_chan.oid_length <= MAX_OID_BYTES)
                    && (total <= MAX_SHORT_LEN);
  assign comm_ok  = (phase_r == PH_COMM) && (comm_left_r != 7'd0);
  assign oid_ok   = (phase_r == PH_OID) && (oid_left_r != 6'd0);
  assign comm_dec = comm_left_r - 7'd1;
  assign oid_dec  = oid_left_r - 6'd1;

  // Next frame state.
  always_comb begin
    phase_nxt     = phase_r;
    comm_left_nxt = comm_left_r;
    oid_left_nxt  = oid_left_r;
    saved_len_nxt = saved_len_r;
    if (accept) begin
      case (kind)
        KIND_START: begin
          if (start_ok) begin
            saved_len_nxt = in_chan.oid_length;
            comm_left_nxt = in_chan.community_length;
            oid_left_nxt  = in_chan.oid_length;
            if (in_chan.community_length != 7'd0) begin
              phase_nxt = PH_COMM;
            end else if (in_chan.oid_length != 6'd0) begin
              phase_nxt = PH_OID;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            phase_nxt     = PH_IDLE;
            comm_left_nxt = 7'd0;
            oid_left_nxt  = 6'd0;
          end
        end
        KIND_COMM: begin
          if (comm_ok) begin
            comm_left_nxt = comm_dec;
            if (comm_dec == 7'd0) begin
              oid_left_nxt = saved_len_r;
              phase_nxt    = (saved_len_r == 6'd0) ? PH_IDLE : PH_OID;
            end
          end else begin
            phase_nxt     = PH_IDLE;
            comm_left_nxt = 7'd0;
            oid_left_nxt  = 6'd0;
          end
        end
        KIND_OID: begin
          if (oid_ok) begin
            oid_left_nxt = oid_dec;
            if (oid_dec == 6'd0) begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            phase_nxt     = PH_IDLE;
            comm_left_nxt = 7'd0;
            oid_left_nxt  = 6'd0;
          end
        end
        default: begin
          phase_nxt     = PH_IDLE;
          comm_left_nxt = 7'd0;
          oid_left_nxt  = 6'd0;
        end
      endcase
    end
  end

  // Command that describes the bytes this item causes.
  always_comb begin
    push_cmd          = '0;
    push_cmd.op       = OP_ERR;
    push_cmd.data     = in_chan.data_byte;
    push_cmd.len      = in_chan.oid_length;
    push_cmd.req_id   = in_chan.req_number;
    push_cmd.next_req = in_chan.next_request;
    case (kind)
      KIND_START: begin
        if (start_ok) begin
          push_cmd.op       = OP_HEAD;
          push_cmd.data     = {1'b0, in_chan.community_length};
          push_cmd.do_pdu   = (in_chan.community_length == 7'd0);
          push_cmd.do_close = (in_chan.community_length == 7'd0)
                              && (in_chan.oid_length == 6'd0);
        end
      end
      KIND_COMM: begin
        if (comm_ok) begin
          push_cmd.op       = OP_PASS;
          push_cmd.do_pdu   = (comm_dec == 7'd0);
          push_cmd.do_close = (comm_dec == 7'd0) && (saved_len_r == 6'd0);
        end
      end
      KIND_OID: begin
        if (oid_ok) begin
          push_cmd.op       = OP_PASS;
          push_cmd.do_close = (oid_dec == 6'd0);
        end
      end
      default: begin
        push_cmd.op = OP_ERR;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      comm_left_r <= 7'd0;
      oid_left_r  <= 6'd0;
      saved_len_r <= 6'd0;
    end else begin
      phase_r     <= phase_nxt;
      comm_left_r <= comm_left_nxt;
      oid_left_r  <= oid_left_nxt;
      saved_len_r <= saved_len_nxt;
    end
  end

endmodule

/* hdl/sgrf_queue.sv */
// Four-entry command queue between the front end and the back end.
module sgrf_queue import sgrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                   slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count_r != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QUEUE_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QUEUE_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/sgrf_back.sv */
// Back end: expands queued commands into frame bytes through a registered output.
module sgrf_back import sgrf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  cmd_t         pop_cmd,
  sgrf_out_if.source   out_chan
);

  logic       busy_r, busy_nxt;
  step_t      step_r, step_nxt;
  logic       do_pdu_r;
  logic       do_close_r;
  logic [7:0] data_r;
  logic [6:0] comm_size_r;
  logic [5:0] oid_len_r;
  logic [7:0] req_id_r;
  logic       next_req_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_err_r;

  logic       emit;
  logic       seg_done;
  step_t      step_adv;
  logic       finishing;
  logic       pop;
  step_t      start_step;

  assign emit = busy_r && (!out_valid_r || out_chan.ready);

  // Step sequencing across the head, pass, error, PDU and closing segments.
  always_comb begin
    seg_done = 1'b0;
    step_adv = step_r + step_t'(1);
    case (step_r)
      STEP_HEAD_END, STEP_PASS: begin
        if (do_pdu_r) begin
          step_adv = STEP_PDU;
        end else if (do_close_r) begin
          step_adv = STEP_NULL;
        end else begin
          seg_done = 1'b1;
        end
      end
      STEP_ERR: begin
        seg_done = 1'b1;
      end
      STEP_PDU_END: begin
        if (do_close_r) begin
          step_adv = STEP_NULL;
        end else begin
          seg_done = 1'b1;
        end
      end
      STEP_END: begin
        seg_done = 1'b1;
      end
      default: begin
        step_adv = step_r + step_t'(1);
      end
    endcase
  end

  assign finishing = !busy_r || (emit && seg_done);
  assign pop       = finishing && pop_valid;
  assign pop_ready = finishing;

  // First step of a newly taken command.
  always_comb begin
    case (pop_cmd.op)
      OP_HEAD: start_step = STEP_HEAD;
      OP_PASS: start_step = STEP_PASS;
      default: start_step = STEP_ERR;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (pop) begin
      busy_nxt = 1'b1;
      step_nxt = start_step;
    end else if (finishing) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      step_nxt = step_adv;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_HEAD;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Command and frame parameters; the frame ones are captured by a head command.
  always_ff @(posedge clk) begin
    if (pop) begin
      do_pdu_r   <= pop_cmd.do_pdu;
      do_close_r <= pop_cmd.do_close;
      data_r     <= pop_cmd.data;
      if (pop_cmd.op == OP_HEAD) begin
        comm_size_r <= pop_cmd.data[6:0];
        oid_len_r   <= pop_cmd.len;
        req_id_r    <= pop_cmd.req_id;
        next_req_r  <= pop_cmd.next_req;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= frame_byte(step_r, comm_size_r, oid_len_r, req_id_r, next_req_r, data_r);
      out_last_r <= (step_r == STEP_ERR) || (step_r == STEP_END);
      out_err_r  <= (step_r == STEP_ERR);
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;
  assign out_chan.error    = out_err_r;

endmodule

/* hdl/snmp_get_request_framer.sv */
// SNMPv2c GetRequest/GetNextRequest framer with short-form BER lengths.
// Throughput: one input item per cycle while the four-entry command queue has room;
// the back end emits one byte per cycle while the output is ready, and a start item yields 7 to 29 bytes.
// Reset: synchronous active-low; clears the frame phase, counters, queue and output valid.
module snmp_get_request_framer import sgrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sgrf_in_if.sink     in_chan,
  sgrf_out_if.source  out_chan
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  sgrf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sgrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sgrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_chan  (out_chan)
  );

endmodule

/* sim/snmp_get_request_framer_tb.sv */
// Self-checking testbench for the SNMP GetRequest framer: directed table, then random frames.
module snmp_get_request_framer_tb import sgrf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One input item as driven onto the request channel.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [6:0] comm_size;
    logic [5:0] oid_len;
    logic [7:0] req_id;
    logic       next_req;
  } req_item_t;

  // One byte of the encoded frame with its flags.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       err;
  } frame_out_t;

  // A row of the directed table; golden is used only where typed is set.
  typedef struct packed {
    req_item_t  item;
    logic       typed;
    frame_out_t golden;
  } stim_row_t;

  localparam frame_out_t ERR_RESULT = '{8'h00, 1'b1, 1'b1};
  localparam frame_out_t NO_GOLDEN  = '0;
  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_ITEMS  = 70;
  localparam int IDLE_LIMIT    = 400;
  localparam int MAX_BURST     = 29;

  logic clk = 1'b0;
  logic rst_n;

  sgrf_in_if  in_chan ();
  sgrf_out_if out_chan ();

  snmp_get_request_framer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Framer state as tracked by the predictor.
  phase_t     fr_phase;
  logic [6:0] comm_left;
  logic [5:0] oid_left;
  logic [5:0] oid_len_r;
  logic [7:0] req_id_r;
  logic       next_r;

  // Bytes produced by the latest accepted item, and the bytes still owed by the DUT.
  frame_out_t burst [MAX_BURST];
  int         burst_n;
  frame_out_t frame_bytes_due [$];

  // Item currently on the request channel, with its typed expectation if any.
  req_item_t  cur_item;
  logic       cur_typed;
  frame_out_t cur_golden;

  stim_row_t  directed [DIRECTED_ROWS];
  int         items_sent;
  int         mismatch_count;
  int         idle_cycles;
  int         in_calm;
  int         out_calm;

  function automatic void add_byte(logic [7:0] b, logic l, logic e);
    burst[burst_n] = '{b, l, e};
    burst_n++;
  endfunction

  // An error result always stands alone and drops any open frame.
  function automatic void abort_frame();
    fr_phase  = PH_IDLE;
    comm_left = '0;
    oid_left  = '0;
    add_byte(BYTE_ZERO, 1'b1, 1'b1);
  endfunction

  function automatic void close_frame();
    add_byte(TAG_NULL, 1'b0, 1'b0);
    add_byte(BYTE_ZERO, 1'b1, 1'b0);
    fr_phase = PH_IDLE;
  endfunction

  // PDU tag through the OID header; an empty OID closes the frame right away.
  function automatic void pdu_bytes();
    logic [7:0] len8;
    len8 = {2'b00, oid_len_r};
    add_byte(next_r ? TAG_GETNEXT : TAG_GET, 1'b0, 1'b0);
    add_byte(len8 + 8'd20, 1'b0, 1'b0);
    add_byte(TAG_INT, 1'b0, 1'b0);
    add_byte(8'h04, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(req_id_r, 1'b0, 1'b0);
    for (int i = 0; i < 2; i++) begin
      add_byte(TAG_INT, 1'b0, 1'b0);
      add_byte(8'h01, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
    end
    add_byte(TAG_SEQ, 1'b0, 1'b0);
    add_byte(len8 + 8'd6, 1'b0, 1'b0);
    add_byte(TAG_SEQ, 1'b0, 1'b0);
    add_byte(len8 + 8'd4, 1'b0, 1'b0);
    add_byte(TAG_OID, 1'b0, 1'b0);
    add_byte(len8, 1'b0, 1'b0);
    oid_left = oid_len_r;
    if (oid_len_r == 6'd0) begin
      close_frame();
    end else begin
      fr_phase = PH_OID;
    end
  endfunction

  // Work out the frame bytes that one accepted item causes.
  function automatic void frame_predict(req_item_t it);
    int total;
    burst_n = 0;
    total = int'(it.comm_size) + int'(it.oid_len) + 27;
    case (kind_t'(it.kind))
      KIND_START: begin
        if (fr_phase != PH_IDLE) begin
          abort_frame();
        end else if (it.oid_len > MAX_OID_BYTES || total > int'(MAX_SHORT_LEN)) begin
          abort_frame();
        end else begin
          oid_len_r = it.oid_len;
          req_id_r  = it.req_id;
          next_r    = it.next_req;
          comm_left = it.comm_size;
          add_byte(TAG_SEQ, 1'b0, 1'b0);
          add_byte(total[7:0], 1'b0, 1'b0);
          add_byte(TAG_INT, 1'b0, 1'b0);
          add_byte(8'h01, 1'b0, 1'b0);
          add_byte(8'h01, 1'b0, 1'b0);
          add_byte(TAG_OCTETS, 1'b0, 1'b0);
          add_byte({1'b0, it.comm_size}, 1'b0, 1'b0);
          if (it.comm_size == 7'd0) begin
            pdu_bytes();
          end else begin
            fr_phase = PH_COMM;
          end
        end
      end
      KIND_COMM: begin
        if (fr_phase != PH_COMM || comm_left == 7'd0) begin
          abort_frame();
        end else begin
          add_byte(it.data, 1'b0, 1'b0);
          comm_left = comm_left - 7'd1;
          if (comm_left == 7'd0) pdu_bytes();
        end
      end
      KIND_OID: begin
        if (fr_phase != PH_OID || oid_left == 6'd0) begin
          abort_frame();
        end else begin
          add_byte(it.data, 1'b0, 1'b0);
          oid_left = oid_left - 6'd1;
          if (oid_left == 6'd0) close_frame();
        end
      end
      default: abort_frame();
    endcase
  endfunction

  function automatic req_item_t pack_item(kind_t k, logic [7:0] d, logic [6:0] c,
                                          logic [5:0] n, logic [7:0] id, logic nx);
    req_item_t it;
    it = '{k, d, c, n, id, nx};
    return it;
  endfunction

  function automatic stim_row_t mk_row(kind_t k, logic [7:0] d, logic [6:0] c, logic [5:0] n,
                                       logic [7:0] id, logic nx, logic typed, frame_out_t g);
    stim_row_t r;
    r = '{pack_item(k, d, c, n, id, nx), typed, g};
    return r;
  endfunction

  // Per-item random wait, with occasional stretches of no waiting at all.
  function automatic int pick_wait(inout int calm);
    int w;
    if (calm > 0) begin
      calm--;
      w = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      w = 0;
    end else begin
      w = $urandom_range(0, 3);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input frame_out_t want, input frame_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected byte %h last %b error %b, got byte %h last %b error %b",
               $realtime, what, want.b, want.last, want.err, got.b, got.last, got.err);
    end
  endtask

  // Drive one item at the falling edge and hold it until the DUT takes it.
  task automatic send_item(input req_item_t it, input logic typed, input frame_out_t gold);
    int        w;
    req_item_t drv;
    drv = it;
    case (kind_t'(it.kind))
      KIND_START: drv.data = 8'($urandom);
      KIND_COMM, KIND_OID: begin
        drv.comm_size = 7'($urandom);
        drv.oid_len   = 6'($urandom);
        drv.req_id    = 8'($urandom);
        drv.next_req  = 1'($urandom);
      end
      default: begin
        drv.data      = 8'($urandom);
        drv.comm_size = 7'($urandom);
        drv.oid_len   = 6'($urandom);
        drv.req_id    = 8'($urandom);
        drv.next_req  = 1'($urandom);
      end
    endcase
    w = pick_wait(in_calm);
    if (w > 0) begin
      in_chan.valid = 1'b0;
      repeat (w) @(negedge clk);
    end
    cur_item   = drv;
    cur_typed  = typed;
    cur_golden = gold;
    in_chan.kind             = drv.kind;
    in_chan.data_byte        = drv.data;
    in_chan.community_length = drv.comm_size;
    in_chan.oid_length       = drv.oid_len;
    in_chan.req_number       = drv.req_id;
    in_chan.next_request     = drv.next_req;
    in_chan.valid            = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Start item, then community and OID bytes, stopping after cut items in all.
  task automatic play_frame(input int c, input int n, input int cut);
    send_item(pack_item(KIND_START, 8'h00, c[6:0], n[5:0], 8'($urandom), 1'($urandom)),
              1'b0, NO_GOLDEN);
    for (int i = 0; i < cut - 1; i++) begin
      send_item(pack_item((i < c) ? KIND_COMM : KIND_OID, 8'($urandom), '0, '0, '0, 1'b0),
                1'b0, NO_GOLDEN);
    end
  endtask

  // Predict on every accepted input item.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      frame_predict(cur_item);
      if (cur_typed) begin
        frame_bytes_due.push_back(cur_golden);
      end else begin
        for (int i = 0; i < burst_n; i++) frame_bytes_due.push_back(burst[i]);
      end
    end
  end

  // Compare every accepted output byte with the oldest expectation.
  always @(posedge clk) begin
    frame_out_t got;
    frame_out_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.out_byte, out_chan.last, out_chan.error};
      if (frame_bytes_due.size() == 0) begin
        report_mismatch("unexpected byte", NO_GOLDEN, got);
      end else begin
        want = frame_bytes_due.pop_front();
        if (got.b !== want.b || got.last !== want.last || got.err !== want.err) begin
          report_mismatch("byte mismatch", want, got);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("snmp_get_request_framer_tb failed");
        $finish;
      end
    end
  end

  // Output side: random stalls before each byte is taken.
  initial begin
    int w;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      w = pick_wait(out_calm);
      if (w > 0) begin
        out_chan.ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Reset, directed table, random frames, drain.
  initial begin
    int pick;
    int c;
    int n;
    int full;
    int cut;
    int over;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = '0;
    in_chan.data_byte = '0;
    in_chan.community_length = '0;
    in_chan.oid_length = '0;
    in_chan.req_number = '0;
    in_chan.next_request = 1'b0;
    cur_item = '0;
    cur_typed = 1'b0;
    cur_golden = '0;
    fr_phase = PH_IDLE;
    comm_left = '0;
    oid_left = '0;
    oid_len_r = '0;
    req_id_r = '0;
    next_r = 1'b0;
    burst_n = 0;
    items_sent = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    in_calm = 0;
    out_calm = 0;

    // Out-of-sequence items right after reset, size limits, aborts and pass-through extremes.
    directed[0]  = mk_row(KIND_COMM,  8'h11, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[1]  = mk_row(KIND_OID,   8'h22, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[2]  = mk_row(KIND_BAD,   8'h33, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[3]  = mk_row(KIND_START, 8'h00, 7'd0, 6'd0, 8'hFF, 1'b1, 1'b0, NO_GOLDEN);
    directed[4]  = mk_row(KIND_START, 8'h00, 7'd127, 6'd0, 8'h00, 1'b0, 1'b1, ERR_RESULT);
    directed[5]  = mk_row(KIND_START, 8'h00, 7'd0, 6'd33, 8'h00, 1'b0, 1'b1, ERR_RESULT);
    directed[6]  = mk_row(KIND_START, 8'h00, 7'd0, 6'd63, 8'hFF, 1'b1, 1'b1, ERR_RESULT);
    directed[7]  = mk_row(KIND_START, 8'h00, 7'd3, 6'd2, 8'h00, 1'b0, 1'b0, NO_GOLDEN);
    directed[8]  = mk_row(KIND_COMM,  8'hFF, '0, '0, '0, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0});
    directed[9]  = mk_row(KIND_START, 8'h00, 7'd1, 6'd1, 8'h12, 1'b0, 1'b1, ERR_RESULT);
    directed[10] = mk_row(KIND_START, 8'h00, 7'd2, 6'd1, 8'h5A, 1'b1, 1'b0, NO_GOLDEN);
    directed[11] = mk_row(KIND_COMM,  8'h00, '0, '0, '0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0});
    directed[12] = mk_row(KIND_OID,   8'h2B, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[13] = mk_row(KIND_START, 8'h00, 7'd1, 6'd1, 8'h80, 1'b0, 1'b0, NO_GOLDEN);
    directed[14] = mk_row(KIND_COMM,  8'hAA, '0, '0, '0, 1'b0, 1'b0, NO_GOLDEN);
    directed[15] = mk_row(KIND_COMM,  8'h55, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[16] = mk_row(KIND_START, 8'h00, 7'd100, 6'd0, 8'h7E, 1'b1, 1'b0, NO_GOLDEN);
    directed[17] = mk_row(KIND_BAD,   8'h00, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[18] = mk_row(KIND_START, 8'h00, 7'd69, 6'd32, 8'h01, 1'b0, 1'b1, ERR_RESULT);
    directed[19] = mk_row(KIND_START, 8'h00, 7'd0, 6'd32, 8'h01, 1'b0, 1'b0, NO_GOLDEN);
    directed[20] = mk_row(KIND_OID,   8'h2B, '0, '0, '0, 1'b0, 1'b1, '{8'h2B, 1'b0, 1'b0});
    directed[21] = mk_row(KIND_COMM,  8'h06, '0, '0, '0, 1'b0, 1'b1, ERR_RESULT);
    directed[22] = mk_row(KIND_START, 8'h00, 7'd0, 6'd1, 8'hC3, 1'b1, 1'b0, NO_GOLDEN);
    directed[23] = mk_row(KIND_OID,   8'h7F, '0, '0, '0, 1'b0, 1'b0, NO_GOLDEN);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed[i].item, directed[i].typed, directed[i].golden);
    end

    // Random part: mostly well-formed frames, some cut short, some at the length limit, some noise.
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        c = $urandom_range(0, 10);
        n = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(0, 8);
        full = 1 + c + n;
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full) : full;
        play_frame(c, n, cut);
        if (cut < full) begin
          case ($urandom_range(0, 2))
            0: send_item(pack_item(KIND_START, '0, 7'($urandom), 6'($urandom), 8'($urandom),
                                   1'($urandom)), 1'b0, NO_GOLDEN);
            1: send_item(pack_item(KIND_BAD, '0, '0, '0, '0, 1'b0), 1'b0, NO_GOLDEN);
            default: send_item(pack_item((cut <= c) ? KIND_OID : KIND_COMM, 8'($urandom),
                                         '0, '0, '0, 1'b0), 1'b0, NO_GOLDEN);
          endcase
        end
      end else if (pick == 7) begin
        // Message length at 127 is accepted, one more is rejected.
        n = $urandom_range(0, 32);
        over = $urandom_range(0, 1);
        c = 100 - n + over;
        play_frame(c, n, (over != 0) ? 1 : $urandom_range(2, 5));
        if (over == 0) send_item(pack_item(KIND_BAD, '0, '0, '0, '0, 1'b0), 1'b0, NO_GOLDEN);
      end else begin
        send_item(pack_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom),
                            6'($urandom), 8'($urandom), 1'($urandom)), 1'b0, NO_GOLDEN);
        if (fr_phase != PH_IDLE) begin
          send_item(pack_item(KIND_BAD, '0, '0, '0, '0, 1'b0), 1'b0, NO_GOLDEN);
        end
      end
    end
    in_chan.valid = 1'b0;

    // Drain every owed byte, then watch for anything stray.
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
      $display("snmp_get_request_framer_tb passed");
    end else begin
      $display("snmp_get_request_framer_tb failed");
    end
    $finish;
  end

endmodule
